// File: design/osa_pkg.sv
// osa_pkg: shared types and constants of the owned slot allocator
// no dependencies; imported by osa_tables, osa_mod and owned_slot_allocator
package osa_pkg;

  localparam int DEF_NUM_SLOTS = 64;
  localparam int ID_W          = 7;
  localparam int RND_W         = 16;
  localparam int OP_W          = 2;

  localparam logic [ID_W-1:0] CFG_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_VIEW    = 2'd0;
  localparam logic [OP_W-1:0] OP_ANY     = 2'd1;
  localparam logic [OP_W-1:0] OP_GIVEN   = 2'd2;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

  // table access requests, indexes zero-based
  typedef struct packed {
    logic            own_rd;
    logic [ID_W-1:0] own_rd_idx;
    logic            own_wr;
    logic [ID_W-1:0] own_wr_idx;
    logic [ID_W-1:0] own_wr_data;
    logic            hold_rd;
    logic [ID_W-1:0] hold_rd_idx;
    logic            hold_wr;
    logic [ID_W-1:0] hold_wr_idx;
    logic            hold_wr_data;
  } tbl_ctl_t;

  typedef struct packed {
    logic            granted;
    logic [ID_W-1:0] slot;
    logic [ID_W-1:0] owner;
    logic            last;
  } res_t;

endpackage

// File: design/osa_tables.sv
// osa_tables: owner table and holds-a-slot flags, one read and one write port each
// depends on osa_pkg; runs a clearing pass over every entry after reset
module osa_tables #(
  parameter int NUM_SLOTS = osa_pkg::DEF_NUM_SLOTS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  osa_pkg::tbl_ctl_t        ctl,
  output logic [osa_pkg::ID_W-1:0] own_q,
  output logic                     hold_q,
  output logic                     clearing
);
  import osa_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int AW    = (IDX_W > ID_W) ? IDX_W : ID_W;

  function automatic logic [IDX_W-1:0] addr_of(input logic [ID_W-1:0] idx);
    logic [AW-1:0] w;
    w = AW'(idx);
    return w[IDX_W-1:0];
  endfunction

  logic [ID_W-1:0]  owner_mem [NUM_SLOTS];
  logic             hold_mem  [NUM_SLOTS];
  logic [IDX_W-1:0] clr_idx;

  logic             own_we;
  logic [IDX_W-1:0] own_wa;
  logic [ID_W-1:0]  own_wd;
  logic             hold_we;
  logic [IDX_W-1:0] hold_wa;
  logic             hold_wd;

  always_comb begin
    if (clearing) begin
      own_we  = 1'b1;
      own_wa  = clr_idx;
      own_wd  = '0;
      hold_we = 1'b1;
      hold_wa = clr_idx;
      hold_wd = 1'b0;
    end else begin
      own_we  = ctl.own_wr;
      own_wa  = addr_of(ctl.own_wr_idx);
      own_wd  = ctl.own_wr_data;
      hold_we = ctl.hold_wr;
      hold_wa = addr_of(ctl.hold_wr_idx);
      hold_wd = ctl.hold_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == IDX_W'(NUM_SLOTS - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= IDX_W'(clr_idx + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (own_we) begin
      owner_mem[own_wa] <= own_wd;
    end
    if (ctl.own_rd) begin
      own_q <= owner_mem[addr_of(ctl.own_rd_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (hold_we) begin
      hold_mem[hold_wa] <= hold_wd;
    end
    if (ctl.hold_rd) begin
      hold_q <= hold_mem[addr_of(ctl.hold_rd_idx)];
    end
  end

endmodule

// File: design/osa_mod.sv
// osa_mod: restoring remainder unit, one dividend bit per cycle
// depends on osa_pkg; done pulses in the cycle after the last step
module osa_mod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [osa_pkg::RND_W-1:0] dividend,
  input  logic [osa_pkg::ID_W-1:0]  divisor,
  output logic                      done,
  output logic [osa_pkg::ID_W-1:0]  remainder
);
  import osa_pkg::*;

  localparam int STEP_W = $clog2(RND_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [RND_W-1:0]  dvd;
  logic [ID_W-1:0]   div_q;
  logic [ID_W-1:0]   rem;
  logic [ID_W:0]     trial;

  assign trial     = {rem, dvd[RND_W-1]};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= STEP_W'(step + 1'b1);
        if (step == STEP_W'(RND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      div_q <= divisor;
      rem   <= '0;
    end else if (busy) begin
      dvd <= {dvd[RND_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem <= ID_W'(trial - {1'b0, div_q});
      end else begin
        rem <= trial[ID_W-1:0];
      end
    end
  end

endmodule

// File: design/owned_slot_allocator.sv
// owned_slot_allocator: top level, operation sequencer, output register and config
// depends on osa_pkg, osa_tables and osa_mod
//
// Keeps an owner for each slot and a holds-a-slot flag per requester. After reset
// a clearing pass over every slot runs with s_tready low. One transaction is
// worked at a time; with n active slots a view reads the slots one by one, an
// allocate-any runs a scan counting free slots, the 16-step remainder unit and
// a scan to the chosen slot, and allocate-given and release check a single slot.
// The pace is set by the single read port of the owner table and the bit-serial
// remainder unit; a stalled output holds the sequencer while it waits. The
// output register lets the next transaction be taken while a result waits.
module owned_slot_allocator #(
  parameter int NUM_SLOTS = osa_pkg::DEF_NUM_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data,     // slots_in_use
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,      // operation, requester_id, slot_number, random_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,      // granted, result_slot, slot_owner, zero pad
  output logic        m_tlast       // last
);
  import osa_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_VIEW   = 3'd1;
  localparam logic [2:0] ST_COUNT  = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_SEARCH = 3'd4;
  localparam logic [2:0] ST_CHECK  = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0]      state, state_next;
  logic [ID_W-1:0] slots_in_use;
  logic [ID_W-1:0] n_act;
  logic [ID_W-1:0] n_q, n_q_next;
  logic [ID_W-1:0] idx, idx_next;
  logic [ID_W-1:0] free_cnt, free_cnt_next;
  logic [ID_W-1:0] seen, seen_next;
  logic [OP_W-1:0] op_q, op_q_next;
  logic [ID_W-1:0] rid_q, rid_q_next;
  logic [ID_W-1:0] slot_q, slot_q_next;
  logic [RND_W-1:0] rnd_q, rnd_q_next;
  logic            rid_ok_q, rid_ok_q_next;
  res_t            res, res_next;
  res_t            out_reg, out_data;
  logic            out_valid, out_load, out_free;

  logic [OP_W-1:0]  in_op;
  logic [ID_W-1:0]  in_rid;
  logic [ID_W-1:0]  in_slot;
  logic [RND_W-1:0] in_rnd;
  logic             in_rid_ok, in_slot_ok;

  tbl_ctl_t        ctl;
  logic [ID_W-1:0] own_q;
  logic            hold_q;
  logic            clearing;
  logic            div_start, div_done;
  logic [ID_W-1:0] div_divisor, div_rem;
  logic [ID_W-1:0] idx_inc, free_inc;

  assign in_op   = s_tdata[1:0];
  assign in_rid  = s_tdata[8:2];
  assign in_slot = s_tdata[15:9];
  assign in_rnd  = s_tdata[31:16];

  always_comb begin
    if (slots_in_use == '0) begin
      n_act = ID_W'(1);
    end else if (32'(slots_in_use) > NUM_SLOTS) begin
      n_act = ID_W'(NUM_SLOTS);
    end else begin
      n_act = slots_in_use;
    end
  end

  assign in_rid_ok  = (in_rid != '0) && (in_rid <= n_act);
  assign in_slot_ok = (in_slot != '0) && (in_slot <= n_act);
  assign s_tready   = (state == ST_IDLE) && !clearing;
  assign out_free   = !out_valid || m_tready;
  assign idx_inc    = ID_W'(idx + 1'b1);
  assign free_inc   = ID_W'(free_cnt + ((own_q == '0) ? 1'b1 : 1'b0));

  osa_tables #(.NUM_SLOTS(NUM_SLOTS)) u_tables (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .own_q    (own_q),
    .hold_q   (hold_q),
    .clearing (clearing)
  );

  osa_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rnd_q),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    state_next    = state;
    n_q_next      = n_q;
    idx_next      = idx;
    free_cnt_next = free_cnt;
    seen_next     = seen;
    op_q_next     = op_q;
    rid_q_next    = rid_q;
    slot_q_next   = slot_q;
    rnd_q_next    = rnd_q;
    rid_ok_q_next = rid_ok_q;
    res_next      = res;
    ctl           = '0;
    div_start     = 1'b0;
    div_divisor   = free_inc;
    out_load      = 1'b0;
    out_data      = res;

    case (state)
      ST_IDLE: begin
        if (s_tvalid && !clearing) begin
          n_q_next      = n_act;
          op_q_next     = in_op;
          rid_q_next    = in_rid;
          slot_q_next   = in_slot;
          rnd_q_next    = in_rnd;
          rid_ok_q_next = in_rid_ok;
          idx_next      = '0;
          free_cnt_next = '0;
          case (in_op)
            OP_VIEW: begin
              ctl.own_rd     = 1'b1;
              ctl.own_rd_idx = '0;
              state_next     = ST_VIEW;
            end
            OP_ANY: begin
              if (!in_rid_ok) begin
                res_next   = '{1'b0, '0, '0, 1'b1};
                state_next = ST_EMIT;
              end else begin
                ctl.own_rd      = 1'b1;
                ctl.own_rd_idx  = '0;
                ctl.hold_rd     = 1'b1;
                ctl.hold_rd_idx = ID_W'(in_rid - 1'b1);
                state_next      = ST_COUNT;
              end
            end
            default: begin
              if (!in_slot_ok) begin
                res_next   = '{1'b0, in_slot, '0, 1'b1};
                state_next = ST_EMIT;
              end else begin
                ctl.own_rd      = 1'b1;
                ctl.own_rd_idx  = ID_W'(in_slot - 1'b1);
                ctl.hold_rd     = in_rid_ok;
                ctl.hold_rd_idx = ID_W'(in_rid - 1'b1);
                state_next      = ST_CHECK;
              end
            end
          endcase
        end
      end

      ST_VIEW: begin
        if (out_free) begin
          out_load = 1'b1;
          out_data = '{1'b0, idx_inc, own_q, (idx_inc == n_q)};
          if (idx_inc == n_q) begin
            state_next = ST_IDLE;
          end else begin
            ctl.own_rd     = 1'b1;
            ctl.own_rd_idx = idx_inc;
            idx_next       = idx_inc;
          end
        end
      end

      ST_COUNT: begin
        free_cnt_next = free_inc;
        if (idx_inc == n_q) begin
          if (free_inc == '0) begin
            res_next   = '{1'b0, '0, '0, 1'b1};
            state_next = ST_EMIT;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end else begin
          ctl.own_rd     = 1'b1;
          ctl.own_rd_idx = idx_inc;
          idx_next       = idx_inc;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          ctl.own_rd     = 1'b1;
          ctl.own_rd_idx = '0;
          idx_next       = '0;
          seen_next      = '0;
          state_next     = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        if ((own_q == '0) && (seen == div_rem)) begin
          state_next = ST_EMIT;
          if (hold_q) begin
            res_next = '{1'b0, idx_inc, '0, 1'b1};
          end else begin
            ctl.own_wr       = 1'b1;
            ctl.own_wr_idx   = idx;
            ctl.own_wr_data  = rid_q;
            ctl.hold_wr      = 1'b1;
            ctl.hold_wr_idx  = ID_W'(rid_q - 1'b1);
            ctl.hold_wr_data = 1'b1;
            res_next         = '{1'b1, idx_inc, rid_q, 1'b1};
          end
        end else begin
          if (own_q == '0) begin
            seen_next = ID_W'(seen + 1'b1);
          end
          ctl.own_rd     = 1'b1;
          ctl.own_rd_idx = idx_inc;
          idx_next       = idx_inc;
        end
      end

      ST_CHECK: begin
        state_next = ST_EMIT;
        res_next   = '{1'b0, slot_q, own_q, 1'b1};
        if (rid_ok_q) begin
          if (op_q == OP_GIVEN) begin
            if ((own_q == '0) && !hold_q) begin
              ctl.own_wr       = 1'b1;
              ctl.own_wr_idx   = ID_W'(slot_q - 1'b1);
              ctl.own_wr_data  = rid_q;
              ctl.hold_wr      = 1'b1;
              ctl.hold_wr_idx  = ID_W'(rid_q - 1'b1);
              ctl.hold_wr_data = 1'b1;
              res_next         = '{1'b1, slot_q, rid_q, 1'b1};
            end
          end else begin
            if ((own_q == rid_q) && hold_q) begin
              ctl.own_wr       = 1'b1;
              ctl.own_wr_idx   = ID_W'(slot_q - 1'b1);
              ctl.own_wr_data  = '0;
              ctl.hold_wr      = 1'b1;
              ctl.hold_wr_idx  = ID_W'(rid_q - 1'b1);
              ctl.hold_wr_data = 1'b0;
              res_next         = '{1'b1, slot_q, '0, 1'b1};
            end
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data   = res;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slots_in_use <= CFG_RESET;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        slots_in_use <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_q      <= n_q_next;
    idx      <= idx_next;
    free_cnt <= free_cnt_next;
    seen     <= seen_next;
    op_q     <= op_q_next;
    rid_q    <= rid_q_next;
    slot_q   <= slot_q_next;
    rnd_q    <= rnd_q_next;
    rid_ok_q <= rid_ok_q_next;
    res      <= res_next;
    if (out_load) begin
      out_reg <= out_data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_reg.owner, out_reg.slot, out_reg.granted};
  assign m_tlast  = out_reg.last;

endmodule

// File: dv/tb_owned_slot_allocator.sv
// tb_owned_slot_allocator: self-checking stream testbench for the owned slot allocator
// depends on osa_pkg and the owned_slot_allocator rtl; a slot-table predictor feeds a result queue
// directed, register-extreme, random and backpressure tests run in turn from one initial block
module tb_owned_slot_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import osa_pkg::*;

  localparam int NUM_SLOTS     = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 28;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [6:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // operation, requester_id, slot_number, random_value
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // granted, result_slot, slot_owner, zero pad
  logic        m_tlast;   // last

  logic [6:0] active_cfg;
  logic [6:0] owner_of [NUM_SLOTS];
  bit         holds_slot [NUM_SLOTS];
  res_t       expected_results [$];
  int         errors = 0;
  int         cycles = 0;
  bit         src_gaps = 1'b1;
  int         hold_token = 0;

  owned_slot_allocator #(.NUM_SLOTS(NUM_SLOTS)) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_owned_slot_allocator: FAIL");
      $finish;
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int active_slots();
    int n;
    n = active_cfg;
    if (n == 0) n = 1;
    if (n > NUM_SLOTS) n = NUM_SLOTS;
    return n;
  endfunction

  function automatic void queue_result(logic g, logic [6:0] slot, logic [6:0] owner, logic l);
    res_t r;
    r.granted = g;
    r.slot    = slot;
    r.owner   = owner;
    r.last    = l;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void predict_results(logic [1:0] op, logic [6:0] rid, logic [6:0] slot,
                                          logic [15:0] rnd);
    int n;
    bit rid_ok;
    bit slot_ok;
    int free_cnt;
    int pick;
    int seen;
    int chosen;
    n        = active_slots();
    rid_ok   = rid >= 1 && rid <= n;
    slot_ok  = slot >= 1 && slot <= n;
    free_cnt = 0;
    seen     = 0;
    chosen   = 0;
    case (op)
      OP_VIEW: begin
        for (int i = 0; i < n; i++)
          queue_result(1'b0, 7'(i + 1), owner_of[i], i + 1 == n);
      end
      OP_ANY: begin
        if (!rid_ok) begin
          queue_result(1'b0, 7'd0, 7'd0, 1'b1);
          return;
        end
        for (int i = 0; i < n; i++)
          if (owner_of[i] == 7'd0) free_cnt++;
        if (free_cnt == 0) begin
          queue_result(1'b0, 7'd0, 7'd0, 1'b1);
          return;
        end
        pick = int'(rnd) % free_cnt;
        for (int i = 0; i < n && chosen == 0; i++) begin
          if (owner_of[i] == 7'd0) begin
            if (seen == pick) chosen = i + 1;
            seen++;
          end
        end
        if (holds_slot[rid - 1]) begin
          queue_result(1'b0, 7'(chosen), 7'd0, 1'b1);
        end else begin
          owner_of[chosen - 1] = rid;
          holds_slot[rid - 1]  = 1'b1;
          queue_result(1'b1, 7'(chosen), rid, 1'b1);
        end
      end
      default: begin
        if (!slot_ok) begin
          queue_result(1'b0, slot, 7'd0, 1'b1);
        end else if (!rid_ok) begin
          queue_result(1'b0, slot, owner_of[slot - 1], 1'b1);
        end else if (op == OP_GIVEN) begin
          if (owner_of[slot - 1] != 7'd0 || holds_slot[rid - 1]) begin
            queue_result(1'b0, slot, owner_of[slot - 1], 1'b1);
          end else begin
            owner_of[slot - 1] = rid;
            holds_slot[rid - 1] = 1'b1;
            queue_result(1'b1, slot, rid, 1'b1);
          end
        end else begin
          if (owner_of[slot - 1] != rid || !holds_slot[rid - 1]) begin
            queue_result(1'b0, slot, owner_of[slot - 1], 1'b1);
          end else begin
            owner_of[slot - 1] = 7'd0;
            holds_slot[rid - 1] = 1'b0;
            queue_result(1'b1, slot, 7'd0, 1'b1);
          end
        end
      end
    endcase
  endfunction

  // sink side: random gaps, calm stretches and a long hold on request
  initial begin : sink
    int stall_left;
    int calm_left;
    int hold_seen;
    stall_left = 0;
    calm_left  = 0;
    hold_seen  = 0;
    m_tready   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen  = hold_token;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(50, 200);
        else stall_left = idle_gap();
      end
    end
  end

  function automatic void check_field(string name, logic [6:0] want, logic [6:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual tdata %h tlast %b",
                 $time, m_tdata, m_tlast);
      end else begin
        want = expected_results.pop_front();
        check_field("granted", 7'(want.granted), 7'(m_tdata[0]));
        check_field("result_slot", want.slot, m_tdata[7:1]);
        check_field("slot_owner", want.owner, m_tdata[14:8]);
        check_field("last", 7'(want.last), 7'(m_tlast));
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [6:0] rid, logic [6:0] slot, logic [15:0] rnd);
    int gap;
    gap = src_gaps ? idle_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rnd, slot, rid, op};
    do @(posedge clk); while (!s_tready);
    predict_results(op, rid, slot, rnd);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_active(logic [6:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    active_cfg = value;
    @(posedge clk);
  endtask

  task automatic send_random_item();
    int n;
    int r;
    int owned [$];
    logic [1:0]  op;
    logic [6:0]  rid;
    logic [6:0]  slot;
    logic [15:0] rnd;
    n    = active_slots();
    r    = $urandom_range(0, 99);
    rnd  = 16'($urandom_range(0, 16'hFFFF));
    rid  = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, n));
    slot = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, n));
    if (r < 6) begin
      op = OP_VIEW;
    end else if (r < 40) begin
      op = OP_ANY;
    end else if (r < 65) begin
      op = OP_GIVEN;
    end else begin
      op = OP_RELEASE;
      for (int k = 1; k <= n; k++)
        if (owner_of[k - 1] != 7'd0) owned.insert(owned.size(), k);
      if (owned.size() != 0 && $urandom_range(0, 9) < 7) begin
        slot = 7'(owned[$urandom_range(0, owned.size() - 1)]);
        if ($urandom_range(0, 4) != 0) rid = owner_of[slot - 1];
      end
    end
    send_item(op, rid, slot, rnd);
  endtask

  task automatic test_directed();
    send_item(OP_VIEW, 7'd1, 7'd1, 16'd0);
    send_item(OP_GIVEN, 7'd1, 7'd1, 16'd0);
    send_item(OP_GIVEN, 7'd2, 7'd1, 16'd0);
    send_item(OP_GIVEN, 7'd1, 7'd2, 16'd0);
    send_item(OP_ANY, 7'd1, 7'd0, 16'd0);
    send_item(OP_ANY, 7'd64, 7'd127, 16'hFFFF);
    send_item(OP_ANY, 7'd0, 7'd3, 16'd7);
    send_item(OP_ANY, 7'd127, 7'd3, 16'd7);
    send_item(OP_GIVEN, 7'd0, 7'd5, 16'd0);
    send_item(OP_GIVEN, 7'd3, 7'd0, 16'd0);
    send_item(OP_GIVEN, 7'd3, 7'd127, 16'hFFFF);
    send_item(OP_RELEASE, 7'd2, 7'd1, 16'd0);
    send_item(OP_RELEASE, 7'd1, 7'd1, 16'd0);
    send_item(OP_RELEASE, 7'd1, 7'd1, 16'd0);
    send_item(OP_RELEASE, 7'd127, 7'd64, 16'd0);
    send_item(OP_GIVEN, 7'd64, 7'd64, 16'd0);
    send_item(OP_VIEW, 7'd127, 7'd127, 16'hFFFF);
  endtask

  task automatic test_active_count();
    wait_drain();
    set_active(7'd1);
    send_item(OP_VIEW, 7'd1, 7'd1, 16'd0);
    send_item(OP_ANY, 7'd1, 7'd1, 16'd0);
    send_item(OP_ANY, 7'd1, 7'd1, 16'd5);
    send_item(OP_ANY, 7'd2, 7'd1, 16'd5);
    wait_drain();
    set_active(7'd0);
    send_item(OP_VIEW, 7'd1, 7'd1, 16'd0);
    send_item(OP_RELEASE, 7'd1, 7'd1, 16'd0);
    wait_drain();
    set_active(7'd127);
    send_item(OP_VIEW, 7'd1, 7'd1, 16'd0);
    // shrink then grow again, high slots keep their owners
    wait_drain();
    set_active(7'd4);
    send_item(OP_VIEW, 7'd1, 7'd1, 16'd0);
    send_item(OP_GIVEN, 7'd2, 7'd5, 16'd0);
    wait_drain();
    set_active(7'd64);
    send_item(OP_VIEW, 7'd1, 7'd1, 16'd0);
  endtask

  task automatic test_random_traffic();
    logic [6:0] settings [RANDOM_PHASES];
    settings = '{7'd64, 7'd8, 7'd127, 7'd3, 7'd0, 7'd1, 7'd16, 7'd64};
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drain();
      set_active(p == RANDOM_PHASES - 1 ? 7'($urandom_range(0, 127)) : settings[p]);
      src_gaps = ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) send_random_item();
    end
    src_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    wait_drain();
    set_active(7'd64);
    src_gaps = 1'b0;
    hold_token <= hold_token + 1;
    repeat (12) send_random_item();
    wait_drain();
    src_gaps = 1'b1;
    repeat (10) send_random_item();
  endtask

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_data   = 7'd0;
    s_tvalid   = 1'b0;
    s_tdata    = 32'd0;
    active_cfg = CFG_RESET;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      owner_of[i]   = 7'd0;
      holds_slot[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // clearing pass after reset
    do @(posedge clk); while (!s_tready);
    test_directed();
    test_active_count();
    test_random_traffic();
    test_backpressure();
    wait_drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_owned_slot_allocator: PASS");
    end else begin
      $display("tb_owned_slot_allocator: FAIL");
    end
    $finish;
  end

endmodule
